// File: src/plce_pkg.sv
// Shared types and constants for the piecewise linear curve evaluator.
// No dependencies; the controller, datapath and top level import it.
package plce_pkg;

   localparam int LEVEL_W = 32;
   localparam int LENGTH_W = 32;
   localparam int FRAME_W = 32;
   localparam int INDEX_W = 4;
   localparam int COUNT_W = 5;
   localparam int FRAC_W = 16;

   // request tdata layout, lowest bit first
   localparam int REQ_IDX_LSB = 0;
   localparam int REQ_LVL_LSB = REQ_IDX_LSB + INDEX_W;
   localparam int REQ_LEN_LSB = REQ_LVL_LSB + LEVEL_W;
   localparam int REQ_FRM_LSB = REQ_LEN_LSB + LENGTH_W;
   localparam int REQ_USED_W = REQ_FRM_LSB + FRAME_W;
   localparam int REQ_DATA_W = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = LEVEL_W;

   // ratio divider: quotient bits, one per step
   localparam int DIV_STEPS = FRAC_W;
   localparam int DIV_CNT_W = 4;
   localparam int RATIO_W = FRAC_W + 1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic start;
      logic accum;
      logic take_seg;
      logic take_next;
      logic div_step;
      logic mult;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic below;
      logic seg_zero;
   } dp_status_type;

endpackage

// File: src/plce_dp.sv
// Datapath of the curve evaluator: point tables, segment sum, ratio divider,
// multiplier and output register. Uses plce_pkg; driven by plce_ctrl.
module plce_dp #(
   parameter int MAX_POINTS = 16,
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  plce_pkg::ctrl_cmd_type          cmd,
   input  logic [IDX_W-1:0]                rd_addr,
   output plce_pkg::dp_status_type         status,
   input  logic [plce_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic [plce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser
);
   import plce_pkg::*;

   localparam int AW = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

   logic [LEVEL_W-1:0]  lvl_mem [MAX_POINTS];
   logic [LENGTH_W-1:0] len_mem [MAX_POINTS];
   logic [LEVEL_W-1:0]  rd_lvl_ff;
   logic [LENGTH_W-1:0] rd_len_ff;

   logic [INDEX_W-1:0]  req_index;
   logic [AW-1:0]       wr_index_wide;
   logic [IDX_W-1:0]    wr_addr;
   logic [LEVEL_W-1:0]  req_level;
   logic [LENGTH_W-1:0] req_length;
   logic [FRAME_W-1:0]  req_frame;

   logic [FRAME_W-1:0]  frame_ff, sum_ff, sum_in;
   logic [LENGTH_W-1:0] seg_ff, off_ff, off_in;
   logic [LEVEL_W-1:0]  cur_ff, nxt_ff;
   logic                zflag_ff, sat_ff;
   logic [LENGTH_W-1:0] rem_ff, rem_in;
   logic [FRAC_W-1:0]   quo_ff, quo_in;
   logic [LENGTH_W:0]   rem_shift;
   logic                rem_ge;
   logic [RATIO_W-1:0]  ratio;
   logic signed [LEVEL_W:0]              diff;
   logic signed [LEVEL_W+RATIO_W+1:0]    prod_ff;
   logic signed [LEVEL_W+2:0]            step, res;
   logic [LEVEL_W-1:0]  res_sat;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic                rsp_flag_ff;

   assign req_index = req_tdata[REQ_IDX_LSB +: INDEX_W];
   assign req_level = req_tdata[REQ_LVL_LSB +: LEVEL_W];
   assign req_length = req_tdata[REQ_LEN_LSB +: LENGTH_W];
   assign req_frame = req_tdata[REQ_FRM_LSB +: FRAME_W];
   assign wr_index_wide = AW'(req_index);
   assign wr_addr = wr_index_wide[IDX_W-1:0];

   // point tables, registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         lvl_mem[wr_addr] <= req_level;
         len_mem[wr_addr] <= req_length;
      end
      rd_lvl_ff <= lvl_mem[rd_addr];
      rd_len_ff <= len_mem[rd_addr];
   end

   assign status.below = ({1'b0, sum_ff} + {1'b0, rd_len_ff}) < {1'b0, frame_ff};
   assign status.seg_zero = (rd_len_ff == '0);

   assign sum_in = sum_ff + rd_len_ff;
   assign off_in = (frame_ff > sum_ff) ? (frame_ff - sum_ff) : '0;

   // restoring division step, remainder stays below the segment length
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge = rem_shift >= {1'b0, seg_ff};
   always_comb begin
      rem_in = rem_ge ? LENGTH_W'(rem_shift - {1'b0, seg_ff}) : rem_shift[LENGTH_W-1:0];
      quo_in = {quo_ff[FRAC_W-2:0], rem_ge};
   end

   assign ratio = sat_ff ? RATIO_W'(1 << FRAC_W) : {1'b0, quo_ff};
   assign diff = $signed({nxt_ff[LEVEL_W-1], nxt_ff}) - $signed({cur_ff[LEVEL_W-1], cur_ff});

   // arithmetic shift floors toward minus infinity
   assign step = prod_ff[LEVEL_W+RATIO_W+1:FRAC_W];
   assign res = $signed({{3{cur_ff[LEVEL_W-1]}}, cur_ff}) + step;
   always_comb begin
      priority if (res > $signed({3'b000, 1'b0, {(LEVEL_W-1){1'b1}}})) begin
         res_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
      end else if (res < $signed({3'b111, 1'b1, {(LEVEL_W-1){1'b0}}})) begin
         res_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
         res_sat = res[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         frame_ff <= req_frame;
         sum_ff <= '0;
      end else if (cmd.accum) begin
         sum_ff <= sum_in;
      end
      if (cmd.take_seg) begin
         seg_ff <= rd_len_ff;
         cur_ff <= rd_lvl_ff;
         off_ff <= off_in;
         zflag_ff <= status.seg_zero;
      end
      if (cmd.take_next) begin
         nxt_ff <= rd_lvl_ff;
         rem_ff <= off_ff;
         quo_ff <= '0;
         sat_ff <= off_ff >= seg_ff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.mult) begin
         prod_ff <= $signed({{(RATIO_W+1){diff[LEVEL_W]}}, diff})
                    * $signed({{(LEVEL_W+2){1'b0}}, ratio});
      end
      if (cmd.load_out) begin
         rsp_level_ff <= zflag_ff ? cur_ff : res_sat;
         rsp_flag_ff <= zflag_ff;
      end
   end

   assign rsp_tdata = rsp_level_ff;
   assign rsp_tuser = rsp_flag_ff;

   a_sum_below_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.accum |=> (sum_ff < frame_ff))
      else $error("segment sum reached the frame while walking");

   a_off_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.take_seg |=> (off_ff <= frame_ff))
      else $error("segment offset exceeds frame");

   a_rem_below_seg: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && !sat_ff) |-> (rem_ff < seg_ff))
      else $error("divider remainder not below segment length");

endmodule

// File: src/plce_ctrl.sv
// Controller of the curve evaluator: handshakes, point count register,
// segment walk index and divider step count. Uses plce_pkg; drives plce_dp.
module plce_ctrl #(
   parameter int MAX_POINTS = 16,
   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_tuser,
   input  logic [plce_pkg::INDEX_W-1:0] req_index,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [plce_pkg::COUNT_W-1:0] csr_data,
   output plce_pkg::ctrl_cmd_type       cmd,
   output logic [IDX_W-1:0]             rd_addr,
   input  plce_pkg::dp_status_type      status
);
   import plce_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SEARCH = 6'b000010,
      ST_NEXT   = 6'b000100,
      ST_DIV    = 6'b001000,
      ST_MUL    = 6'b010000,
      ST_FIN    = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]       n_use;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   req_fire, more, out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      priority if (count_ff == '0) begin
         n_use = CNT_W'(1);
      end else if (32'(count_ff) > MAX_POINTS) begin
         n_use = CNT_W'(MAX_POINTS);
      end else begin
         n_use = CNT_W'(count_ff);
      end
   end

   // another point follows the one at the walk index
   assign more = (CNT_W'(idx_ff) + CNT_W'(1)) < n_use;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      div_cnt_in = div_cnt_ff;
      rd_addr = '0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == CMD_EVAL) begin
                  cmd.start = 1'b1;
                  idx_in = '0;
                  state_in = ST_SEARCH;
               end else begin
                  cmd.wr_en = 32'(req_index) < MAX_POINTS;
               end
            end
         end
         ST_SEARCH: begin
            rd_addr = more ? (idx_ff + IDX_W'(1)) : '0;
            if (more && status.below) begin
               cmd.accum = 1'b1;
               idx_in = idx_ff + IDX_W'(1);
            end else begin
               cmd.take_seg = 1'b1;
               state_in = status.seg_zero ? ST_FIN : ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.take_next = 1'b1;
            div_cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_W'(1);
         idx_ff <= '0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (CNT_W'(idx_ff) < n_use))
      else $error("segment walk index beyond points in use");

   a_eval_starts_walk: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == CMD_EVAL) |=> (state_ff == ST_SEARCH && idx_ff == '0))
      else $error("evaluate word did not start the segment walk");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result loaded but not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && rsp_valid_ff) |-> rsp_tready)
      else $error("pending result overwritten");

endmodule

// File: src/piecewise_linear_curve_eval.sv
// Piecewise linear curve evaluator: write words store curve points, evaluate
// words return the level interpolated at a frame. Uses plce_pkg, plce_ctrl, plce_dp.
// Evaluate word: a walk over the segments passed, then DIV_STEPS divider steps, the
// multiply and the result load; a zero-length segment goes from the walk to the load.
// Input is held off until the result is loaded, so no new word is taken during an evaluate.
// Synchronous reset sets the point count to 1; the point tables are not cleared.
module piecewise_linear_curve_eval #(
   parameter int MAX_POINTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // point_index, point_level, segment_length, frame, zero pad
   input  logic [plce_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // curve_level
   output logic [plce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // zero_length_flag
   output logic                            rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [plce_pkg::COUNT_W-1:0]    csr_data
);
   import plce_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   ctrl_cmd_type    cmd;
   dp_status_type   status;
   logic [IDX_W-1:0] rd_addr;

   plce_ctrl #(
      .MAX_POINTS(MAX_POINTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_index  (req_tdata[REQ_IDX_LSB +: INDEX_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .status     (status)
   );

   plce_dp #(
      .MAX_POINTS(MAX_POINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
